// ===== rtl/wpo_pkg.sv =====
`default_nettype none
package wpo_pkg;
    localparam int TableSize = 1024;
    localparam int AddrW = $clog2(TableSize);
    localparam int FracW = 16;
    localparam int PhaseW = AddrW + FracW;
    localparam int NumOsc = 9;
    localparam int OscW = 4;
    localparam int PwMin = 30;
    localparam int PwMax = 1000;
    localparam int IncShift = 34 - FracW;

    localparam logic [3:0] CFG_SQUARE = 4'd0;
    localparam logic [3:0] CFG_RAMP = 4'd1;
    localparam logic [3:0] CFG_SINE = 4'd2;
    localparam logic [3:0] CFG_FIRST = 4'd3;
    localparam logic [3:0] CFG_SECOND = 4'd4;
    localparam logic [3:0] CFG_PW = 4'd5;
    localparam logic [3:0] CFG_PITCH = 4'd6;

    localparam logic [1:0] KIND_RAMP = 2'd0;
    localparam logic [1:0] KIND_PULSE = 2'd1;
    localparam logic [1:0] KIND_SINE = 2'd2;

    // queue entry between front and back
    typedef struct packed {
        logic               is_write;
        logic               table_sel;
        logic [AddrW-1:0]   addr;
        logic signed [15:0] data;
        logic signed [31:0] rate;
        logic [AddrW-1:0]   off;
        logic               key_on;
        logic [15:0]        brill;
        logic signed [15:0] detune;
    } t_cmd;

    function automatic logic [1:0] osc_kind(input logic [OscW-1:0] k);
        case (k)
            4'd0, 4'd1, 4'd2: osc_kind = KIND_RAMP;
            4'd3, 4'd4, 4'd5: osc_kind = KIND_PULSE;
            default:          osc_kind = KIND_SINE;
        endcase
    endfunction

    function automatic logic [1:0] osc_partial(input logic [OscW-1:0] k);
        case (k)
            4'd0, 4'd3, 4'd6: osc_partial = 2'd0;
            4'd1, 4'd4, 4'd7: osc_partial = 2'd1;
            default:          osc_partial = 2'd2;
        endcase
    endfunction

    function automatic logic [10:0] osc_coef(input logic [OscW-1:0] k);
        case (k)
            4'd1: osc_coef = 11'd721;
            4'd2: osc_coef = 11'd1507;
            4'd3: osc_coef = 11'd459;
            4'd4: osc_coef = 11'd852;
            4'd5: osc_coef = 11'd1114;
            4'd6: osc_coef = 11'd328;
            4'd7: osc_coef = 11'd852;
            4'd8: osc_coef = 11'd1769;
            default: osc_coef = 11'd0;
        endcase
    endfunction
endpackage
`default_nettype wire

// ===== rtl/wpo_ram.sv =====
`default_nettype none
module wpo_ram #(
    parameter int Width = 16,
    parameter int Depth = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/wpo_front.sv =====
`default_nettype none
module wpo_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_action,
    input  wire logic signed [31:0]    i_rate,
    input  wire logic signed [10:0]    i_pwm,
    input  wire logic                  i_key_on,
    input  wire logic [15:0]           i_brill,
    input  wire logic signed [15:0]    i_detune,
    input  wire logic                  i_table_sel,
    input  wire logic [9:0]            i_addr,
    input  wire logic signed [15:0]    i_data,
    input  wire logic [9:0]            i_pulse_width,
    output wpo_pkg::t_cmd              o_cmd,
    output logic                       o_valid,
    input  wire logic                  i_pop
);
    import wpo_pkg::*;

    // two-entry queue
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic signed [12:0] w_off;
    logic       w_push;

    always_comb begin
        w_off = $signed({3'b0, i_pulse_width}) + 13'(i_pwm);
        if (w_off < 13'sd30) begin
            w_off = 13'(PwMin);
        end else if (w_off > 13'sd1000) begin
            w_off = 13'(PwMax);
        end
        n_cmd.is_write  = i_action;
        n_cmd.table_sel = i_table_sel;
        n_cmd.addr      = AddrW'(i_addr);
        n_cmd.data      = i_data;
        n_cmd.rate      = i_rate;
        n_cmd.off       = AddrW'(w_off);
        n_cmd.key_on    = i_key_on;
        n_cmd.brill     = i_brill;
        n_cmd.detune    = i_detune;
    end

    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("accept while full");
endmodule
`default_nettype wire

// ===== rtl/wpo_back.sv =====
`default_nettype none
module wpo_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wpo_pkg::t_cmd           i_cmd,
    input  wire logic               i_valid,
    output logic                    o_pop,
    input  wire logic [15:0]        i_square_level,
    input  wire logic [15:0]        i_ramp_level,
    input  wire logic [15:0]        i_sine_level,
    input  wire logic [15:0]        i_first_level,
    input  wire logic [15:0]        i_second_level,
    input  wire logic [23:0]        i_pitch_scale,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [15:0]      o_main,
    output logic signed [15:0]      o_sine
);
    import wpo_pkg::*;

    // steps per oscillator: gain, reads of i, i+1, i+off, i+off+1, then arithmetic
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GAIN1 = 4'd1;
    localparam logic [3:0] S_GAIN2 = 4'd2;
    localparam logic [3:0] S_RD0 = 4'd3;
    localparam logic [3:0] S_RD1 = 4'd4;
    localparam logic [3:0] S_RD2 = 4'd5;
    localparam logic [3:0] S_RD3 = 4'd6;
    localparam logic [3:0] S_WAIT = 4'd7;
    localparam logic [3:0] S_MUL = 4'd8;
    localparam logic [3:0] S_ACC = 4'd9;
    localparam logic [3:0] S_TUNE = 4'd10;
    localparam logic [3:0] S_INC = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0]  r_state;
    logic [OscW-1:0] r_k;
    logic [PhaseW-1:0] r_phase [NumOsc];
    t_cmd        r_cmd;
    logic [31:0] r_gprod;
    logic [16:0] r_gain;
    logic signed [16:0] r_ta, r_tb, r_va;
    logic signed [17:0] r_val;
    logic signed [36:0] r_prod;
    logic signed [22:0] r_main, r_sine;
    logic signed [28:0] r_tune;
    logic signed [63:0] r_inc;

    logic [AddrW-1:0] r_raddr;
    logic             r_rsel;
    logic [15:0]      w_ramp_q, w_sine_q;
    logic signed [15:0] w_q;
    logic             w_wr_ramp, w_wr_sine;

    logic [1:0]  w_kind, w_part;
    logic [15:0] w_level, w_plevel;
    logic [AddrW-1:0] w_idx;
    logic [FracW-1:0] w_frac;
    logic signed [17:0] w_diff;
    logic signed [35:0] w_dprod;
    logic signed [16:0] w_interp;
    logic signed [22:0] w_acc_in;
    logic signed [PhaseW:0] w_pn;

    assign w_kind   = osc_kind(r_k);
    assign w_part   = osc_partial(r_k);
    assign w_level  = (w_kind == KIND_RAMP) ? i_ramp_level :
                      (w_kind == KIND_PULSE) ? i_square_level : i_sine_level;
    assign w_plevel = (w_part == 2'd1) ? i_first_level : i_second_level;
    assign w_idx    = r_phase[r_k][PhaseW-1:FracW];
    assign w_frac   = r_phase[r_k][FracW-1:0];
    assign w_q      = r_rsel ? $signed(w_sine_q) : $signed(w_ramp_q);
    assign w_diff   = 18'(r_tb) - 18'(r_ta);
    assign w_dprod  = w_diff * $signed({1'b0, w_frac});
    assign w_interp = r_ta + 17'(w_dprod >>> FracW);
    assign w_acc_in = 23'(r_prod >>> 15);
    assign w_pn     = $signed({1'b0, r_phase[r_k]}) + (PhaseW+1)'(r_inc >>> IncShift);

    assign w_wr_ramp = i_valid && r_state == S_IDLE && i_cmd.is_write && !i_cmd.table_sel;
    assign w_wr_sine = i_valid && r_state == S_IDLE && i_cmd.is_write && i_cmd.table_sel;

    wpo_ram #(.Width(16), .Depth(TableSize)) u_ramp (
        .i_clk(i_clk), .i_we(w_wr_ramp), .i_waddr(i_cmd.addr),
        .i_wdata(i_cmd.data), .i_raddr(r_raddr), .o_rdata(w_ramp_q)
    );
    wpo_ram #(.Width(16), .Depth(TableSize)) u_sine (
        .i_clk(i_clk), .i_we(w_wr_sine), .i_waddr(i_cmd.addr),
        .i_wdata(i_cmd.data), .i_raddr(r_raddr), .o_rdata(w_sine_q)
    );

    assign o_pop = i_valid && r_state == S_IDLE && (i_cmd.is_write || !o_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_k <= '0;
            for (int i = 0; i < NumOsc; i++) begin
                r_phase[i] <= '0;
            end
        end else begin
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop && !i_cmd.is_write) begin
                        if (i_cmd.key_on) begin
                            for (int i = 0; i < 6; i++) begin
                                r_phase[i] <= '0;
                            end
                        end
                        // the queue entry is gone after the pop, keep a copy
                        r_cmd <= i_cmd;
                        r_k <= '0;
                        r_main <= '0;
                        r_sine <= '0;
                        r_state <= S_GAIN1;
                    end
                end
                S_GAIN1: begin
                    r_gprod <= 32'(r_cmd.brill) * 32'(w_level);
                    r_state <= S_GAIN2;
                end
                S_GAIN2: begin
                    if (w_part == 2'd0) begin
                        r_gain <= 17'(w_level);
                    end else begin
                        r_gain <= 17'((48'(r_gprod) * 48'(w_plevel)) >> 31);
                    end
                    r_raddr <= w_idx;
                    r_rsel <= (w_kind == KIND_SINE);
                    r_state <= S_RD0;
                end
                S_RD0: begin
                    if (r_gain == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_raddr <= w_idx + AddrW'(1);
                        r_state <= S_RD1;
                    end
                end
                S_RD1: begin
                    r_ta <= 17'(w_q);
                    r_raddr <= w_idx + r_cmd.off;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_tb <= 17'(w_q);
                    r_raddr <= w_idx + r_cmd.off + AddrW'(1);
                    r_state <= S_RD3;
                end
                S_RD3: begin
                    r_va <= w_interp;
                    r_ta <= 17'(w_q);
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    r_tb <= 17'(w_q);
                    if (w_kind == KIND_PULSE) begin
                        r_state <= S_MUL;
                    end else begin
                        r_val <= 18'(r_va);
                        r_state <= S_ACC;
                    end
                end
                S_MUL: begin
                    r_val <= 18'(r_va) - 18'(w_interp);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_prod <= r_val * $signed({1'b0, r_gain});
                    r_tune <= 29'(r_k == 4'd2 || r_k == 4'd5 || r_k == 4'd8 ?
                        {i_pitch_scale, 3'b0} : r_k == 4'd1 || r_k == 4'd4 || r_k == 4'd7 ?
                        {1'b0, i_pitch_scale, 2'b0} : {2'b0, i_pitch_scale, 1'b0})
                        + 29'((29'($signed({1'b0, osc_coef(r_k)})) * 29'(r_cmd.detune)) >>> 8);
                    r_state <= S_TUNE;
                end
                S_TUNE: begin
                    if (w_kind == KIND_SINE) begin
                        r_sine <= r_sine + w_acc_in;
                    end else begin
                        r_main <= r_main + w_acc_in;
                    end
                    r_inc <= 64'(r_cmd.rate) * 64'(r_tune);
                    r_state <= S_INC;
                end
                S_INC: begin
                    r_phase[r_k] <= PhaseW'(w_pn);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (r_k == OscW'(NumOsc - 1)) begin
                        o_main <= (r_main > 23'sd32767) ? 16'sh7fff :
                                  (r_main < -23'sd32768) ? 16'sh8000 : 16'(r_main);
                        o_sine <= (r_sine > 23'sd32767) ? 16'sh7fff :
                                  (r_sine < -23'sd32768) ? 16'sh8000 : 16'(r_sine);
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_k <= r_k + OscW'(1);
                        r_state <= S_GAIN1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k < OscW'(NumOsc)) else $error("oscillator index out of range");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && r_k == OscW'(NumOsc - 1) |-> !o_valid || i_ready)
        else $error("result overwritten");
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
endmodule
`default_nettype wire

// ===== rtl/wavetable_pwm_oscillator_voice.sv =====
// wavetable voice: nine oscillators summed into a main and a sine sample
// s_axis: one item per tvalid&tready; tuser selects audio step (0) or table
// write (1). table writes give no result; each audio step gives one m_axis item.
// cfg channel writes the seven level/width/pitch registers; the user must write
// them only while idle, the block itself does not enforce it. items pass a
// two-entry queue into a sequencer that walks the nine oscillators one at a time
// over the shared table reads and multipliers: gain, four table reads,
// interpolation, gain multiply, accumulation and phase advance, plus a subtract
// step for pulse; a zero-gain oscillator skips to the next and keeps its phase.
// table writes go one per cycle while the queue has room and land in the table
// when the idle sequencer pops them. the result sits in an output register; while
// the receiver stalls the queue still takes items until full, and the sequencer
// holds audio steps until the result is taken. reset clears phases, registers to
// defaults, queue and output valid. tables are undefined until written.
`default_nettype none
module wavetable_pwm_oscillator_voice (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // rate_in[31:0] pwm_in[42:32] key_on[43] brilliance[59:44] detune[75:60]
    // table_sel[76] table_addr[86:77] table_data[102:87], zero to 103
    input  wire logic [103:0] s_axis_tdata,
    // action
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // main_sample[15:0] sine_sample[31:16]
    output logic [31:0]      m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);
    import wpo_pkg::*;

    logic [15:0] r_square, r_ramp, r_sine, r_first, r_second;
    logic [9:0]  r_pw;
    logic [23:0] r_pitch;
    t_cmd        w_cmd;
    logic        w_qvalid, w_pop;
    logic signed [15:0] w_main, w_sine;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square <= 16'd32768;
            r_ramp <= 16'd6554;
            r_sine <= 16'd6554;
            r_first <= 16'd32768;
            r_second <= 16'd32768;
            r_pw <= 10'd512;
            r_pitch <= 24'd65536;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SQUARE: r_square <= i_cfg_data[15:0];
                CFG_RAMP:   r_ramp <= i_cfg_data[15:0];
                CFG_SINE:   r_sine <= i_cfg_data[15:0];
                CFG_FIRST:  r_first <= i_cfg_data[15:0];
                CFG_SECOND: r_second <= i_cfg_data[15:0];
                CFG_PW:     r_pw <= i_cfg_data[9:0];
                CFG_PITCH:  r_pitch <= i_cfg_data;
                default: ;
            endcase
        end
    end

    wpo_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_action(s_axis_tuser),
        .i_rate(s_axis_tdata[31:0]), .i_pwm(s_axis_tdata[42:32]),
        .i_key_on(s_axis_tdata[43]), .i_brill(s_axis_tdata[59:44]),
        .i_detune(s_axis_tdata[75:60]), .i_table_sel(s_axis_tdata[76]),
        .i_addr(s_axis_tdata[86:77]), .i_data(s_axis_tdata[102:87]),
        .i_pulse_width(r_pw),
        .o_cmd(w_cmd), .o_valid(w_qvalid), .i_pop(w_pop)
    );

    wpo_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .i_valid(w_qvalid), .o_pop(w_pop),
        .i_square_level(r_square), .i_ramp_level(r_ramp),
        .i_sine_level(r_sine), .i_first_level(r_first),
        .i_second_level(r_second), .i_pitch_scale(r_pitch),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_main(w_main), .o_sine(w_sine)
    );

    assign m_axis_tdata = {w_sine, w_main};
endmodule
`default_nettype wire

// ===== dv/wavetable_pwm_oscillator_voice_tb.sv =====
`default_nettype none
module wavetable_pwm_oscillator_voice_tb;
    import wpo_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] CfgUnused = 4'd9;
    localparam longint CycleLimit = 4000000;
    localparam int SettleCycles = 200;

    class voice_scoreboard;
        logic [15:0] level_of_kind [3];
        logic [15:0] first_level, second_level;
        logic [9:0]  pulse_width;
        logic [23:0] pitch_scale;
        longint      phase [NumOsc];
        logic signed [15:0] ramp_tab [TableSize];
        logic signed [15:0] sine_tab [TableSize];
        logic [31:0] expected_samples [$];
        int errors, results, steps, writes, key_ons, clamps;

        function new();
            level_of_kind[KIND_PULSE] = 16'd32768;
            level_of_kind[KIND_RAMP]  = 16'd6554;
            level_of_kind[KIND_SINE]  = 16'd6554;
            first_level  = 16'd32768;
            second_level = 16'd32768;
            pulse_width  = 10'd512;
            pitch_scale  = 24'd65536;
            foreach (phase[k]) phase[k] = 0;
            errors = 0; results = 0; steps = 0; writes = 0; key_ons = 0; clamps = 0;
        endfunction

        function void set_reg(logic [3:0] idx, logic [23:0] v);
            case (idx)
                CFG_SQUARE: level_of_kind[KIND_PULSE] = v[15:0];
                CFG_RAMP:   level_of_kind[KIND_RAMP] = v[15:0];
                CFG_SINE:   level_of_kind[KIND_SINE] = v[15:0];
                CFG_FIRST:  first_level = v[15:0];
                CFG_SECOND: second_level = v[15:0];
                CFG_PW:     pulse_width = v[9:0];
                CFG_PITCH:  pitch_scale = v;
                default: ;
            endcase
        endfunction

        function longint lerp(bit sine, longint i, longint f);
            longint a, b;
            a = sine ? sine_tab[i % TableSize] : ramp_tab[i % TableSize];
            b = sine ? sine_tab[(i + 1) % TableSize] : ramp_tab[(i + 1) % TableSize];
            return a + (((b - a) * f) >>> FracW);
        endfunction

        function void note(logic action, logic signed [31:0] rate, logic signed [10:0] pwm,
                           logic key, logic [15:0] brill, logic signed [15:0] det,
                           logic sel, logic [9:0] addr, logic signed [15:0] data);
            int coefs [NumOsc] = '{0, 721, 1507, 459, 852, 1114, 328, 852, 1769};
            longint off, main_sum, sine_sum, gain, lvl, p, i, f, v, tune, inc;
            int kind, part;
            if (action) begin
                if (sel) sine_tab[addr] = data;
                else ramp_tab[addr] = data;
                writes++;
                return;
            end
            steps++;
            if (key) begin
                for (int k = 0; k < 6; k++) phase[k] = 0;
                key_ons++;
            end
            off = longint'(pulse_width) + longint'(pwm);
            if (off < PwMin || off > PwMax) clamps++;
            if (off < PwMin) off = PwMin;
            else if (off > PwMax) off = PwMax;
            main_sum = 0;
            sine_sum = 0;
            for (int k = 0; k < NumOsc; k++) begin
                kind = k < 3 ? KIND_RAMP : (k < 6 ? KIND_PULSE : KIND_SINE);
                part = k % 3;
                lvl = level_of_kind[kind];
                if (part == 0) gain = lvl;
                else gain = (longint'(brill) * lvl
                             * longint'(part == 1 ? first_level : second_level)) >> 31;
                if (gain == 0) continue;
                p = phase[k];
                i = p >> FracW;
                f = p & ((longint'(1) << FracW) - 1);
                if (kind == KIND_SINE) begin
                    v = lerp(1'b1, i, f);
                    sine_sum += (v * gain) >>> 15;
                end else begin
                    v = lerp(1'b0, i, f);
                    if (kind == KIND_PULSE) v -= lerp(1'b0, (i + off) % TableSize, f);
                    main_sum += (v * gain) >>> 15;
                end
                tune = longint'(2 << part) * longint'(pitch_scale)
                     + ((longint'(coefs[k]) * longint'(det)) >>> 8);
                inc = (longint'(rate) * tune) >>> IncShift;
                phase[k] = (p + inc) & ((longint'(1) << PhaseW) - 1);
            end
            if (main_sum > 32767) main_sum = 32767;
            if (main_sum < -32768) main_sum = -32768;
            if (sine_sum > 32767) sine_sum = 32767;
            if (sine_sum < -32768) sine_sum = -32768;
            expected_samples.push_back({sine_sum[15:0], main_sum[15:0]});
        endfunction

        function void check(logic [31:0] got);
            logic [31:0] want;
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected sample %h", $time, got);
                errors++;
                return;
            end
            want = expected_samples.pop_front();
            results++;
            if (got[15:0] !== want[15:0]) begin
                $display("%0t: main_sample expected %0d actual %0d", $time,
                         $signed(want[15:0]), $signed(got[15:0]));
                errors++;
            end
            if (got[31:16] !== want[31:16]) begin
                $display("%0t: sine_sample expected %0d actual %0d", $time,
                         $signed(want[31:16]), $signed(got[31:16]));
                errors++;
            end
        endfunction
    endclass

    logic         i_clk, i_rst_n;
    logic         s_axis_tvalid, s_axis_tready, s_axis_tuser;
    logic [103:0] s_axis_tdata;
    logic         m_axis_tvalid, m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic         i_cfg_valid, o_cfg_ready;
    logic [3:0]   i_cfg_index;
    logic [23:0]  i_cfg_data;

    voice_scoreboard sb;
    longint cycles;
    int hold_request;
    bit sink_relaxed;

    wavetable_pwm_oscillator_voice dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("wavetable_pwm_oscillator_voice_tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // sink: stretches are randomly free-running or broken by random stalls
    initial begin
        int stall_left, stretch;
        m_axis_tready = 1'b0;
        stall_left = 0;
        stretch = 0;
        forever begin
            @(negedge i_clk);
            if (stretch == 0) begin
                sink_relaxed = $urandom_range(0, 2) == 0;
                stretch = $urandom_range(100, 600);
            end
            stretch--;
            if (hold_request > 0) begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                m_axis_tready = 1'b1;
                if (!sink_relaxed && $urandom_range(0, 3) == 0) stall_left = idle_len();
            end
        end
    end

    task automatic send(logic action, logic signed [31:0] rate, logic signed [10:0] pwm,
                        logic key, logic [15:0] brill, logic signed [15:0] det,
                        logic sel, logic [9:0] addr, logic signed [15:0] data);
        int gap;
        gap = idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = action;
        s_axis_tdata = '0;
        s_axis_tdata[31:0] = rate;
        s_axis_tdata[42:32] = pwm;
        s_axis_tdata[43] = key;
        s_axis_tdata[59:44] = brill;
        s_axis_tdata[75:60] = det;
        s_axis_tdata[76] = sel;
        s_axis_tdata[86:77] = addr;
        s_axis_tdata[102:87] = data;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note(action, rate, pwm, key, brill, det, sel, addr, data);
    endtask

    task automatic table_write(logic sel, logic [9:0] addr, logic signed [15:0] data);
        send(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, sel, addr, data);
    endtask

    task automatic audio_step(logic signed [31:0] rate, logic signed [10:0] pwm, logic key,
                              logic [15:0] brill, logic signed [15:0] det);
        send(1'b0, rate, pwm, key, brill, det, $urandom, $urandom, $urandom);
    endtask

    task automatic random_step();
        logic signed [31:0] rate;
        case ($urandom_range(0, 3))
            0: rate = $urandom;
            1: rate = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            default: rate = $urandom_range(1 << 14, 1 << 19);
        endcase
        if ($urandom_range(0, 9) == 0)
            table_write($urandom, $urandom, $urandom);
        else
            audio_step(rate, $urandom, $urandom_range(0, 9) == 0, $urandom, $urandom);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [23:0] v);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.expected_samples.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic load_levels(logic [15:0] sq, logic [15:0] rp, logic [15:0] sn,
                               logic [15:0] p1, logic [15:0] p2, logic [9:0] pw,
                               logic [23:0] pitch);
        write_reg(CFG_SQUARE, sq);
        write_reg(CFG_RAMP, rp);
        write_reg(CFG_SINE, sn);
        write_reg(CFG_FIRST, p1);
        write_reg(CFG_SECOND, p2);
        write_reg(CFG_PW, pw);
        write_reg(CFG_PITCH, pitch);
    endtask

    initial begin
        sb = new();
        cycles = 0;
        hold_request = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // both tables filled before any audio step reads them
        for (int a = 0; a < TableSize; a++) begin
            table_write(1'b0, a, (a == 0) ? -16'sd32768 : (a == TableSize - 1) ? 16'sd32767
                                 : $signed(16'((a * 64) - 32768)));
            table_write(1'b1, a, $urandom);
        end

        // directed steps at reset settings
        audio_step(32'sd0, 11'sd0, 1'b0, 16'hffff, 16'sd0);
        audio_step(32'sh7fffffff, 11'sh3ff, 1'b0, 16'hffff, 16'sh7fff);
        audio_step(32'sh80000000, 11'sh400, 1'b0, 16'h0000, 16'sh8000);
        audio_step(32'sh00010000, -11'sd500, 1'b1, 16'h8000, 16'sd0);
        audio_step(32'sh00020000, 11'sd600, 1'b0, 16'hffff, -16'sd1);
        audio_step(32'sh00400000, 11'sd0, 1'b0, 16'h0001, 16'sd256);
        audio_step(32'shfff00000, 11'sd100, 1'b1, 16'hffff, -16'sd256);
        audio_step(32'sh0ffffff0, -11'sd1024, 1'b0, 16'hffff, 16'sd0);
        table_write(1'b0, 10'd5, 16'sh7fff);
        audio_step(32'sh00003000, 11'sd0, 1'b0, 16'hffff, 16'sd0);
        drain();

        // largest levels and pitch, plus a write to an index past the list
        load_levels(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 10'h3ff, 24'hffffff);
        write_reg(CfgUnused, 24'h123456);
        audio_step(32'sh7fffffff, 11'sh3ff, 1'b0, 16'hffff, 16'sh7fff);
        audio_step(32'sh80000000, -11'sd1024, 1'b1, 16'hffff, 16'sh8000);
        repeat (300) random_step();
        drain();

        // all gains zero: phases hold, outputs stay at zero
        load_levels(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 10'd0, 24'd0);
        repeat (60) random_step();
        drain();
        load_levels(16'd32768, 16'd0, 16'd32768, 16'd0, 16'd32768, 10'd20, 24'd131072);
        repeat (100) random_step();
        drain();

        // mid settings, with a long sink stall so the input side backs up
        load_levels($urandom_range(0, 32768), $urandom_range(0, 32768),
                    $urandom_range(0, 32768), $urandom_range(0, 32768),
                    $urandom_range(0, 32768), $urandom_range(0, 1023), $urandom);
        hold_request = 3000;
        repeat (400) random_step();
        drain();

        load_levels(16'd32768, 16'd6554, 16'd6554, 16'd32768, 16'd32768, 10'd512, 24'd65536);
        repeat (700) random_step();
        drain();

        $display("covered %0d audio steps and %0d table writes, %0d samples checked",
                 sb.steps, sb.writes, sb.results);
        $display("key-on steps %0d, pulse offsets clamped %0d, errors %0d",
                 sb.key_ons, sb.clamps, sb.errors);
        if (sb.errors == 0 && sb.expected_samples.size() == 0) begin
            $display("wavetable_pwm_oscillator_voice_tb: PASS");
        end else begin
            $display("wavetable_pwm_oscillator_voice_tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/wpo_pkg.sv
rtl/wpo_ram.sv
rtl/wpo_front.sv
rtl/wpo_back.sv
rtl/wavetable_pwm_oscillator_voice.sv
dv/wavetable_pwm_oscillator_voice_tb.sv
